FILE: rtl/sbb_pkg.sv
// ----------------------------------------------------------------------------
// sbb_pkg
// Shared constants, format codes and helper functions for the signed packed
// BCD to binary converter.
// ----------------------------------------------------------------------------
package sbb_pkg;

  // Widths of the request and result fields
  localparam int unsigned WORD_W = 32;
  localparam int unsigned FMT_W  = 4;
  localparam int unsigned VAL_W  = 32;

  // Four decimal digits fit in 14 bits, eight in 27 bits
  localparam int unsigned QUAD_W = 14;
  localparam int unsigned MAG_W  = 27;

  // Format codes
  localparam logic [FMT_W-1:0] FMT_U16  = 4'd0;  // unsigned, 4 digits
  localparam logic [FMT_W-1:0] FMT_U32  = 4'd1;  // unsigned, 8 digits
  localparam logic [FMT_W-1:0] FMT_SB16 = 4'd2;  // sign bit above 3 digits
  localparam logic [FMT_W-1:0] FMT_SB32 = 4'd3;  // sign bit above 7 digits
  localparam logic [FMT_W-1:0] FMT_TB16 = 4'd4;  // sign in bit 15
  localparam logic [FMT_W-1:0] FMT_TB32 = 4'd5;  // sign in bit 31
  localparam logic [FMT_W-1:0] FMT_FN16 = 4'd6;  // F top nibble means minus
  localparam logic [FMT_W-1:0] FMT_FN32 = 4'd7;
  localparam logic [FMT_W-1:0] FMT_AF16 = 4'd8;  // F minus, A minus with a leading 1
  localparam logic [FMT_W-1:0] FMT_AF32 = 4'd9;

  // Sign nibble codes
  localparam logic [3:0] NIB_A = 4'hA;
  localparam logic [3:0] NIB_F = 4'hF;

  // Error sentinels
  localparam logic [VAL_W-1:0] SENT16 = 32'd32767;
  localparam logic [VAL_W-1:0] SENT32 = 32'd2147483647;

  // Largest magnitude allowed for a positive result
  function automatic logic [MAG_W-1:0] pos_lim(input logic [FMT_W-1:0] fmt);
    logic [MAG_W-1:0] lim;
    case (fmt)
      FMT_U16:  lim = MAG_W'(9999);
      FMT_U32:  lim = MAG_W'(99999999);
      FMT_SB16: lim = MAG_W'(999);
      FMT_SB32: lim = MAG_W'(9999999);
      FMT_TB16: lim = MAG_W'(7999);
      FMT_TB32: lim = MAG_W'(79999999);
      FMT_FN16: lim = MAG_W'(9999);
      FMT_FN32: lim = MAG_W'(99999999);
      FMT_AF16: lim = MAG_W'(9999);
      FMT_AF32: lim = MAG_W'(99999999);
      default:  lim = '0;
    endcase
    return lim;
  endfunction

  // Largest magnitude allowed for a negative result
  function automatic logic [MAG_W-1:0] neg_lim(input logic [FMT_W-1:0] fmt);
    logic [MAG_W-1:0] lim;
    case (fmt)
      FMT_SB16: lim = MAG_W'(999);
      FMT_SB32: lim = MAG_W'(9999999);
      FMT_TB16: lim = MAG_W'(7999);
      FMT_TB32: lim = MAG_W'(79999999);
      FMT_FN16: lim = MAG_W'(999);
      FMT_FN32: lim = MAG_W'(9999999);
      FMT_AF16: lim = MAG_W'(1999);
      FMT_AF32: lim = MAG_W'(19999999);
      default:  lim = '0;
    endcase
    return lim;
  endfunction

  // Flag any nibble above nine
  function automatic logic has_bad_digit(input logic [WORD_W-1:0] w);
    logic bad;
    bad = 1'b0;
    for (int i = 0; i < WORD_W / 4; i++) begin
      if (w[4*i +: 4] > 4'd9) begin
        bad = 1'b1;
      end
    end
    return bad;
  endfunction

  // Binary value of four packed BCD digits, constant weights only
  function automatic logic [QUAD_W-1:0] quad_val(input logic [15:0] q);
    logic [QUAD_W-1:0] acc;
    acc = QUAD_W'(q[3:0])
        + QUAD_W'(q[7:4])   * QUAD_W'(10)
        + QUAD_W'(q[11:8])  * QUAD_W'(100)
        + QUAD_W'(q[15:12]) * QUAD_W'(1000);
    return acc;
  endfunction

endpackage

FILE: rtl/sbb_if.sv
// ----------------------------------------------------------------------------
// sbb request and result channels
// Valid/ready channels carrying a BCD request and a converted result.
// ----------------------------------------------------------------------------
interface sbb_req_if import sbb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] bcd_word;
  logic [FMT_W-1:0]  format;

  modport source (output valid, output bcd_word, output format, input ready);
  modport sink   (input valid, input bcd_word, input format, output ready);
endinterface

interface sbb_res_if import sbb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic                    bad;

  modport source (output valid, output value, output bad, input ready);
  modport sink   (input valid, input value, input bad, output ready);
endinterface

FILE: rtl/signed_bcd_to_binary.sv
// ----------------------------------------------------------------------------
// signed_bcd_to_binary
// Four-stage pipelined converter from a 32-bit packed BCD word to a signed
// binary value under one of ten sign/width formats.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  : request channel, bcd_word plus a 4-bit format code. A request
//             is taken at a clock edge where valid and ready are both high.
//   out_res : result channel, signed value plus a bad flag. Every request
//             gives exactly one result, in order.
//   A result turns valid once its request has passed through all stages
//   and leaves at an edge where out_res.ready is high; one request
//   enters per cycle while in_req.ready is high. The stages are: format
//   decode and sign strip, digit check and two four-digit partial sums,
//   merge of the halves with a constant multiply by 10000, and range
//   check with negation into the output register.
//   Reset (rst_n low, synchronous) empties all stages; no result is pending
//   afterwards. When the receiver holds out_res.ready low the stages fill
//   up and in_req.ready drops once all four are occupied; each stage only
//   advances when the one after it is free or moving, so nothing is dropped
//   or sent twice.
//   On an error the value carries 32767 or 2147483647 and bad is set.
// ----------------------------------------------------------------------------
module signed_bcd_to_binary import sbb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  sbb_req_if.sink   in_req,
  sbb_res_if.source out_res
);

  // Stage enables: a stage loads when it is empty or its content moves on
  logic en1, en2, en3, en4;

  // Stage 1: decoded format
  logic              v1_r;
  logic [WORD_W-1:0] s1_word_r, s1_word_nxt;
  logic              s1_neg_r, s1_neg_nxt;
  logic              s1_fail_r, s1_fail_nxt;
  logic              s1_err32_r, s1_err32_nxt;
  logic [FMT_W-1:0]  s1_fmt_r;

  // Stage 2: partial sums
  logic              v2_r;
  logic [QUAD_W-1:0] s2_lo_r, s2_hi_r;
  logic              s2_neg_r;
  logic              s2_fail_r, s2_fail_nxt;
  logic              s2_err32_r, s2_err32_nxt;
  logic [FMT_W-1:0]  s2_fmt_r;

  // Stage 3: magnitude and limit
  logic              v3_r;
  logic [MAG_W-1:0]  s3_mag_r, s3_mag_nxt;
  logic [MAG_W-1:0]  s3_lim_r, s3_lim_nxt;
  logic              s3_neg_r;
  logic              s3_fail_r;
  logic              s3_err32_r;

  // Stage 4: output register
  logic              v4_r;
  logic [VAL_W-1:0]  s4_val_r, s4_val_nxt;
  logic              s4_bad_r, s4_bad_nxt;

  assign en4 = !v4_r || out_res.ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_req.ready  = en1;
  assign out_res.valid = v4_r;
  assign out_res.value = $signed(s4_val_r);
  assign out_res.bad   = s4_bad_r;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_req.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // ---- Stage 1: check upper bits, strip the sign, flag unknown codes ----
  always_comb begin
    logic [WORD_W-1:0] w;
    w            = in_req.bcd_word;
    s1_word_nxt  = w;
    s1_neg_nxt   = 1'b0;
    s1_fail_nxt  = 1'b0;
    s1_err32_nxt = 1'b0;
    case (in_req.format)
      FMT_U16: begin
        if (|w[31:16]) s1_fail_nxt = 1'b1;
      end
      FMT_U32: begin
      end
      FMT_SB16: begin
        if (|w[31:13]) s1_fail_nxt = 1'b1;
        s1_neg_nxt  = w[12];
        s1_word_nxt = {20'd0, w[11:0]};
      end
      FMT_SB32: begin
        if (|w[31:29]) begin
          s1_fail_nxt  = 1'b1;
          s1_err32_nxt = 1'b1;
        end
        s1_neg_nxt  = w[28];
        s1_word_nxt = {4'd0, w[27:0]};
      end
      FMT_TB16: begin
        if (|w[31:16]) s1_fail_nxt = 1'b1;
        s1_neg_nxt  = w[15];
        s1_word_nxt = {17'd0, w[14:0]};
      end
      FMT_TB32: begin
        s1_neg_nxt  = w[31];
        s1_word_nxt = {1'b0, w[30:0]};
      end
      FMT_FN16: begin
        if (|w[31:16]) begin
          s1_fail_nxt = 1'b1;
        end else if (w[15:12] == NIB_F) begin
          s1_neg_nxt  = 1'b1;
          s1_word_nxt = {20'd0, w[11:0]};
        end else if (w[15:12] > 4'd9) begin
          s1_fail_nxt  = 1'b1;
          s1_err32_nxt = 1'b1;
        end
      end
      FMT_FN32: begin
        if (w[31:28] == NIB_F) begin
          s1_neg_nxt  = 1'b1;
          s1_word_nxt = {4'd0, w[27:0]};
        end else if (w[31:28] > 4'd9) begin
          s1_fail_nxt  = 1'b1;
          s1_err32_nxt = 1'b1;
        end
      end
      FMT_AF16: begin
        if (|w[31:16]) begin
          s1_fail_nxt = 1'b1;
        end else if (w[15:12] == NIB_A) begin
          s1_neg_nxt  = 1'b1;
          s1_word_nxt = {19'd0, 1'b1, w[11:0]};
        end else if (w[15:12] == NIB_F) begin
          s1_neg_nxt  = 1'b1;
          s1_word_nxt = {20'd0, w[11:0]};
        end else if (w[15:12] > 4'd9) begin
          s1_fail_nxt = 1'b1;
        end
      end
      FMT_AF32: begin
        if (w[31:28] == NIB_A) begin
          s1_neg_nxt  = 1'b1;
          s1_word_nxt = {3'd0, 1'b1, w[27:0]};
        end else if (w[31:28] == NIB_F) begin
          s1_neg_nxt  = 1'b1;
          s1_word_nxt = {4'd0, w[27:0]};
        end else if (w[31:28] > 4'd9) begin
          s1_fail_nxt  = 1'b1;
          s1_err32_nxt = 1'b1;
        end
      end
      default: begin
        s1_fail_nxt  = 1'b1;
        s1_err32_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_word_r  <= s1_word_nxt;
      s1_neg_r   <= s1_neg_nxt;
      s1_fail_r  <= s1_fail_nxt;
      s1_err32_r <= s1_err32_nxt;
      s1_fmt_r   <= in_req.format;
    end
  end

  // ---- Stage 2: reject non-decimal digits, sum each half ----
  always_comb begin
    s2_fail_nxt  = s1_fail_r;
    s2_err32_nxt = s1_err32_r;
    if (!s1_fail_r && has_bad_digit(s1_word_r)) begin
      s2_fail_nxt  = 1'b1;
      s2_err32_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_lo_r    <= quad_val(s1_word_r[15:0]);
      s2_hi_r    <= quad_val(s1_word_r[31:16]);
      s2_neg_r   <= s1_neg_r;
      s2_fail_r  <= s2_fail_nxt;
      s2_err32_r <= s2_err32_nxt;
      s2_fmt_r   <= s1_fmt_r;
    end
  end

  // ---- Stage 3: merge halves, pick the limit for the sign ----
  assign s3_mag_nxt = MAG_W'(s2_hi_r) * MAG_W'(10000) + MAG_W'(s2_lo_r);
  assign s3_lim_nxt = s2_neg_r ? neg_lim(s2_fmt_r) : pos_lim(s2_fmt_r);

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_mag_r   <= s3_mag_nxt;
      s3_lim_r   <= s3_lim_nxt;
      s3_neg_r   <= s2_neg_r;
      s3_fail_r  <= s2_fail_r;
      s3_err32_r <= s2_err32_r;
    end
  end

  // ---- Stage 4: range check, apply sign, choose sentinel ----
  always_comb begin
    logic [VAL_W-1:0] mag_ext;
    mag_ext    = VAL_W'(s3_mag_r);
    s4_bad_nxt = 1'b0;
    s4_val_nxt = s3_neg_r ? (~mag_ext + VAL_W'(1)) : mag_ext;
    if (s3_fail_r) begin
      s4_bad_nxt = 1'b1;
      s4_val_nxt = s3_err32_r ? SENT32 : SENT16;
    end else if (s3_mag_r > s3_lim_r) begin
      s4_bad_nxt = 1'b1;
      s4_val_nxt = SENT32;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_val_r <= s4_val_nxt;
      s4_bad_r <= s4_bad_nxt;
    end
  end

  // ---- Checks ----
  // Errors always carry one of the two sentinels
  a_bad_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.bad) |-> (s4_val_r == SENT16 || s4_val_r == SENT32))
    else $error("error result without sentinel");

  // Good results stay inside the widest format range
  a_good_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.bad) |->
      ($signed(s4_val_r) >= -32'sd79999999 && $signed(s4_val_r) <= 32'sd99999999))
    else $error("good result outside range");

  // Unknown format codes are caught in the first stage
  a_fmt_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && s1_fmt_r > FMT_AF32) |-> (s1_fail_r && s1_err32_r))
    else $error("unknown format not flagged");

  // Backpressure reaches the input only with every stage occupied
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_req.ready |-> (v1_r && v2_r && v3_r && v4_r && !out_res.ready))
    else $error("request stalled with a free stage");

  // A held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.ready) |=> (out_res.valid && $stable(s4_val_r)
      && $stable(s4_bad_r)))
    else $error("stalled result changed");

endmodule
